[src/frc_pkg.sv]
// ----------------------------------------------------------------------------
// frc_pkg
// Types, constants and the CRC-16/ARC byte update for the modem response
// frame checker.
// ----------------------------------------------------------------------------
package frc_pkg;

  localparam int unsigned RX_BUFFER_BYTES = 512;

  localparam logic [7:0]  START_BYTE         = 8'h3e;
  localparam logic [7:0]  END_BYTE           = 8'h3b;
  localparam logic [15:0] CRC_POLY_REFLECTED = 16'ha001;
  localparam logic [15:0] BUFFER_POSITION    = 16'(RX_BUFFER_BYTES);
  localparam logic [15:0] MIN_FRAME_LENGTH   = 16'd5;

  localparam int unsigned CFG_INDEX_WIDTH = 8;
  localparam int unsigned CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPECTED_COMMAND = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPECTED_LENGTH  = 8'd1;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_LENGTH  = 3'd1,
    ERR_COMMAND = 3'd2,
    ERR_END     = 3'd3,
    ERR_CRC     = 3'd4
  } err_t;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [15:0] running_crc;
    logic [15:0] received_crc;
    logic        command_mismatch;
    logic        frame_done;
  } frame_state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] byte_position;
    logic        last;
    logic        frame_ok;
    err_t        error_kind;
  } result_t;

  function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY_REFLECTED;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

[src/frc_if.sv]
// ----------------------------------------------------------------------------
// frc channel interfaces
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface frc_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, operation, rx_byte, input ready);
  modport sink   (input valid, operation, rx_byte, output ready);
endinterface

interface frc_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] byte_position;
  logic        last;
  logic        frame_ok;
  logic [2:0]  error_kind;

  modport source (output valid, data_byte, byte_position, last, frame_ok, error_kind,
                  input ready);
  modport sink   (input valid, data_byte, byte_position, last, frame_ok, error_kind,
                  output ready);
endinterface

interface frc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/modem_response_frame_checker.sv]
// ----------------------------------------------------------------------------
// modem_response_frame_checker
// Hunts for a response frame in a UART byte stream, passes out each frame
// byte with its position and reports the frame status on the last byte.
// A result is registered and offered in the cycle after its request is taken.
// Throughput: one request per cycle; a request is taken while a result
// waits as long as that result is being taken in the same cycle.
// Reset: synchronous; clears registers, frame state and the result slot.
// ----------------------------------------------------------------------------
module modem_response_frame_checker (
  input  logic      clk,
  input  logic      rst,
  frc_req_if.sink   request,
  frc_res_if.source result,
  frc_cfg_if.sink   cfg
);
  import frc_pkg::*;

  logic [7:0]   expected_command;
  logic [15:0]  expected_length;
  frame_state_t state;
  frame_state_t state_next;
  logic         has_result;
  result_t      step_result;
  result_t      out_data;
  logic         out_valid;
  logic         accept;

  frc_step u_step (
    .operation        (request.operation),
    .rx_byte          (request.rx_byte),
    .expected_command (expected_command),
    .expected_length  (expected_length),
    .state            (state),
    .state_next       (state_next),
    .has_result       (has_result),
    .result           (step_result)
  );

  assign cfg.ready     = 1'b1;
  assign request.ready = !out_valid || result.ready;
  assign accept        = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= '0;
      expected_length  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_EXPECTED_COMMAND: expected_command <= cfg.data[7:0];
        REG_EXPECTED_LENGTH:  expected_length  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        out_valid <= has_result;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      out_data <= step_result;
    end
  end

  assign result.valid         = out_valid;
  assign result.data_byte     = out_data.data_byte;
  assign result.byte_position = out_data.byte_position;
  assign result.last          = out_data.last;
  assign result.frame_ok      = out_data.frame_ok;
  assign result.error_kind    = out_data.error_kind;

endmodule

[src/frc_step.sv]
// ----------------------------------------------------------------------------
// frc_step
// Per-request frame logic: hunting, position tracking, CRC update and
// the final length / command / end byte / CRC checks.
// ----------------------------------------------------------------------------
module frc_step (
  input  logic                  operation,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            expected_command,
  input  logic [15:0]           expected_length,
  input  frc_pkg::frame_state_t state,
  output frc_pkg::frame_state_t state_next,
  output logic                  has_result,
  output frc_pkg::result_t      result
);
  import frc_pkg::*;

  logic [15:0] pos;
  logic [15:0] count_inc;
  logic        long_frame;
  logic        in_crc;
  err_t        err;

  assign pos        = state.byte_count;
  assign count_inc  = pos + 16'd1;
  assign long_frame = expected_length >= MIN_FRAME_LENGTH;
  assign in_crc     = (pos >= 16'd1) && (pos <= expected_length - 16'd4);

  always_comb begin
    state_next = state;
    has_result = 1'b0;
    err        = ERR_NONE;
    result     = '{data_byte: rx_byte, byte_position: pos, last: 1'b0,
                   frame_ok: 1'b0, error_kind: ERR_NONE};
    if (op_t'(operation) == OP_RESTART) begin
      state_next = '0;
    end else if (state.frame_done || expected_length == 16'd0) begin
      has_result = 1'b0;
    end else if (pos == 16'd0 && rx_byte != START_BYTE) begin
      has_result = 1'b0;
    end else if (pos >= BUFFER_POSITION) begin
      state_next.frame_done = 1'b1;
      has_result            = 1'b1;
      result = '{data_byte: 8'h00, byte_position: BUFFER_POSITION, last: 1'b1,
                 frame_ok: 1'b0, error_kind: ERR_LENGTH};
    end else begin
      has_result            = 1'b1;
      state_next.byte_count = count_inc;
      if (pos == 16'd1 && rx_byte != expected_command) begin
        state_next.command_mismatch = 1'b1;
      end
      if (long_frame) begin
        if (in_crc) begin
          state_next.running_crc = crc_arc_byte(state.running_crc, rx_byte);
        end else if (pos == expected_length - 16'd3) begin
          state_next.received_crc = {rx_byte, state.received_crc[7:0]};
        end else if (pos == expected_length - 16'd2) begin
          state_next.received_crc = {state.received_crc[15:8], rx_byte};
        end
      end
      if (count_inc == expected_length) begin
        state_next.frame_done = 1'b1;
        if (!long_frame) begin
          err = ERR_LENGTH;
        end else if (state_next.command_mismatch) begin
          err = ERR_COMMAND;
        end else if (rx_byte != END_BYTE) begin
          err = ERR_END;
        end else if (state_next.received_crc != state_next.running_crc) begin
          err = ERR_CRC;
        end
        result.last       = 1'b1;
        result.frame_ok   = (err == ERR_NONE);
        result.error_kind = err;
      end
    end
  end

endmodule

[src/frc_checker.sv]
// ----------------------------------------------------------------------------
// frc_checker
// Port-level assertions for the modem response frame checker.
// ----------------------------------------------------------------------------
module frc_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [7:0]  res_data_byte,
  input logic        res_last,
  input logic        res_frame_ok,
  input logic [2:0]  res_error_kind
);
  import frc_pkg::*;

  a_ok_only_on_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_frame_ok |-> res_last && res_error_kind == ERR_NONE)
    else $error("frame_ok without last or with an error");

  a_no_status_mid_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !res_frame_ok && res_error_kind == ERR_NONE)
    else $error("status given before the last byte");

  a_last_has_verdict: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last |-> res_frame_ok || res_error_kind != ERR_NONE)
    else $error("completed frame with neither ok nor error");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data_byte) && $stable(res_last))
    else $error("stalled result changed");

endmodule

bind modem_response_frame_checker frc_checker u_frc_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_data_byte  (result.data_byte),
  .res_last       (result.last),
  .res_frame_ok   (result.frame_ok),
  .res_error_kind (result.error_kind)
);
